// ===== sv/slvn_pkg.sv =====
package slvn_pkg;

	localparam int PROB_W     = 16;
	localparam int IM_W       = 16;
	localparam int NODE_W     = 11;
	localparam int EDGE_N     = 6;
	localparam int SUB3_N     = 8;
	localparam int IDX_EXT_W  = 17;
	localparam int BETA_W     = 4;
	localparam logic [BETA_W-1:0] BETA_RESET = 4'd4;
	localparam logic [2:0] MAJ_LIMIT = 3'd3;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam logic [2:0] BIT_C = 3'd6;

	typedef logic [2:0] sub_tap_t [3];

	localparam sub_tap_t SUB_IN [SUB3_N] = '{
		'{BIT_C, 3'd1, 3'd2},
		'{BIT_C, 3'd0, 3'd2},
		'{BIT_C, 3'd0, 3'd1},
		'{BIT_C, 3'd4, 3'd5},
		'{BIT_C, 3'd3, 3'd5},
		'{BIT_C, 3'd3, 3'd4},
		'{3'd3, 3'd4, 3'd5},
		'{3'd0, 3'd1, 3'd2}
	};

	typedef struct packed {
		logic [IM_W-1:0]   im;
		logic [PROB_W-1:0] tp;
	} node_word_t;

endpackage

// ===== sv/stochastic_ldpc_variable_node_core.sv =====
// Pipeline: 3 register stages (stage 1, stage 2, result register). Throughput: one word
// per cycle while the output is not stalled; node state is read at accept and written
// from stage 2, with forwarding so updates to the same node back to back see each other.
// A stalled output holds the whole pipeline and drops in_ready. Reset: asynchronous,
// active low; the registered beta shift returns to 4 and a clearing pass then zeroes the
// internal memory and tracking probability of all NODE_COUNT nodes, one per cycle, with
// in_ready low. A node must be loaded before it is updated.
module stochastic_ldpc_variable_node_core
	import slvn_pkg::*;
#(
	parameter int NODE_COUNT = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [BETA_W-1:0]    beta_shift,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [NODE_W-1:0]    node_index,
	input  logic [PROB_W-1:0]    channel_prob,
	input  logic [PROB_W-1:0]    rand_channel,
	input  logic [PROB_W-1:0]    rand_tfm,
	input  logic [SUB3_N-1:0]    im_select,
	input  logic [EDGE_N-1:0]    edge_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [NODE_W-1:0]    node_out,
	output logic [EDGE_N-1:0]    edge_out,
	output logic                 decision
);

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);
	localparam logic [IDX_EXT_W-1:0] NODE_LIMIT = IDX_EXT_W'(NODE_COUNT);

	function automatic logic [2:0] ones6(input logic [EDGE_N-1:0] v);
		logic [2:0] n;
		n = '0;
		for (int i = 0; i < EDGE_N; i++) begin
			n = n + {2'b0, v[i]};
		end
		return n;
	endfunction

	node_word_t mem_q [NODE_COUNT];

	logic [BETA_W-1:0] beta_q;
	logic              clr_busy_q;
	logic [AW-1:0]     clr_q;

	logic en;
	logic acc;

	// stage 1: accepted word and registered node state
	logic                 v_s1;
	logic                 op_s1;
	logic                 inr_s1;
	logic [AW-1:0]        addr_s1;
	logic [NODE_W-1:0]    node_s1;
	logic [PROB_W-1:0]    pch_s1;
	logic [PROB_W-1:0]    rch_s1;
	logic [PROB_W-1:0]    rtf_s1;
	logic [SUB3_N-1:0]    sel_s1;
	logic [EDGE_N-1:0]    ein_s1;
	node_word_t           rd_s1;

	// write not seen by the read at the edge stage 1 was loaded
	logic                 byp_v_q;
	logic [AW-1:0]        byp_addr_q;
	node_word_t           byp_q;

	// stage 2: subunit results
	logic                 v_s2;
	logic                 op_s2;
	logic                 inr_s2;
	logic [AW-1:0]        addr_s2;
	logic [NODE_W-1:0]    node_s2;
	logic                 dec_s2;
	logic [EDGE_N-1:0]    agr_s2;
	logic [EDGE_N-1:0]    val_s2;
	logic                 m_s2;
	logic [IM_W-1:0]      im_s2;
	logic [PROB_W-1:0]    p_s2;
	logic [PROB_W-1:0]    rtf_s2;

	// stage 3: result register
	logic                 v_s3;
	logic [NODE_W-1:0]    node_s3;
	logic [EDGE_N-1:0]    eout_s3;
	logic                 dec_s3;

	logic [IDX_EXT_W-1:0] idx_ext;
	logic [AW-1:0]        addr_in;
	logic                 inr_in;

	logic                 c1;
	logic [6:0]           vec1;
	logic                 dec1;
	node_word_t           fwd1;
	logic [SUB3_N-1:0]    b1;
	logic [IM_W-1:0]      im1;
	logic [EDGE_N-1:0]    agr1;
	logic [EDGE_N-1:0]    val1;
	logic                 m1;
	logic                 x1, y1, z1, oth1;

	logic                 f2;
	logic [EDGE_N-1:0]    eo2;
	logic [IDX_EXT_W-1:0] np2;
	logic [PROB_W-1:0]    psat2;
	logic [PROB_W-1:0]    pwr2;
	logic                 wr_en2;
	node_word_t           wr2;
	logic                 hit_s2;
	logic                 hit_byp;

	assign en        = !v_s3 || out_ready;
	assign in_ready  = en && !clr_busy_q;
	assign acc       = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign idx_ext = {{(IDX_EXT_W - NODE_W){1'b0}}, node_index};
	assign addr_in = idx_ext[AW-1:0];
	assign inr_in  = idx_ext < NODE_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			beta_q <= beta_shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// node state memory
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_q] <= '0;
		end else if (en && wr_en2) begin
			mem_q[addr_s2] <= wr2;
		end
		if (en) begin
			rd_s1 <= mem_q[addr_in];
		end
	end

	// stage 1 logic
	assign hit_s2  = v_s2 && inr_s2 && inr_s1 && (addr_s2 == addr_s1);
	assign hit_byp = byp_v_q && inr_s1 && (byp_addr_q == addr_s1);

	always_comb begin
		priority if (hit_s2) begin
			fwd1 = wr2;
		end else if (hit_byp) begin
			fwd1 = byp_q;
		end else begin
			fwd1 = rd_s1;
		end
	end

	always_comb begin
		c1   = pch_s1 > rch_s1;
		vec1 = {c1, ein_s1};
		dec1 = (op_s1 == OP_UPDATE)
			&& (({1'b0, ones6(ein_s1)} + {3'b0, c1}) > {1'b0, MAJ_LIMIT});
		im1  = fwd1.im;
		b1   = '0;
		x1   = 1'b0;
		y1   = 1'b0;
		z1   = 1'b0;
		for (int k = 0; k < SUB3_N; k++) begin
			x1 = vec1[SUB_IN[k][0]];
			y1 = vec1[SUB_IN[k][1]];
			z1 = vec1[SUB_IN[k][2]];
			if (x1 == y1 && y1 == z1) begin
				b1[k]        = x1;
				im1[2*k]     = x1;
				im1[2*k + 1] = fwd1.im[2*k];
			end else begin
				b1[k] = sel_s1[k] ? fwd1.im[2*k + 1] : fwd1.im[2*k];
			end
		end
		agr1 = '0;
		val1 = '0;
		oth1 = 1'b0;
		for (int k = 0; k < EDGE_N; k++) begin
			oth1    = (k < 3) ? b1[6] : b1[7];
			agr1[k] = b1[k] == oth1;
			val1[k] = b1[k];
		end
		m1 = ones6(val1) > MAJ_LIMIT;
	end

	// stage 2 logic
	always_comb begin
		f2 = p_s2 > rtf_s2;
		for (int k = 0; k < EDGE_N; k++) begin
			eo2[k] = agr_s2[k] ? val_s2[k] : f2;
		end
		np2 = {1'b0, p_s2} - {1'b0, p_s2 >> beta_q}
			+ (m_s2 ? (IDX_EXT_W'(1) << PROB_W) >> beta_q : '0);
		psat2 = np2[PROB_W] ? '1 : np2[PROB_W-1:0];
		pwr2  = ((op_s2 == OP_UPDATE) && (&agr_s2)) ? psat2 : p_s2;
		wr2.im = im_s2;
		wr2.tp = pwr2;
		wr_en2 = v_s2 && inr_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			byp_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= acc;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			byp_v_q <= wr_en2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= op;
			inr_s1  <= inr_in;
			addr_s1 <= addr_in;
			node_s1 <= node_index;
			pch_s1  <= channel_prob;
			rch_s1  <= rand_channel;
			rtf_s1  <= rand_tfm;
			sel_s1  <= im_select;
			ein_s1  <= edge_in;

			byp_addr_q <= addr_s2;
			byp_q      <= wr2;

			op_s2   <= op_s1;
			inr_s2  <= inr_s1;
			addr_s2 <= addr_s1;
			node_s2 <= node_s1;
			dec_s2  <= dec1;
			agr_s2  <= agr1;
			val_s2  <= val1;
			m_s2    <= m1;
			im_s2   <= (op_s1 == OP_UPDATE) ? im1 : '0;
			p_s2    <= (op_s1 == OP_UPDATE) ? fwd1.tp : pch_s1;
			rtf_s2  <= rtf_s1;

			node_s3 <= node_s2;
			eout_s3 <= ((op_s2 == OP_UPDATE) && inr_s2) ? eo2 : '0;
			dec_s3  <= dec_s2;
		end
	end

	assign out_valid = v_s3;
	assign node_out  = node_s3;
	assign edge_out  = eout_s3;
	assign decision  = dec_s3;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v_s1 && !v_s2 && !wr_en2)
		else $error("pipeline active during clearing pass");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(node_out) && $stable(edge_out)
			&& $stable(decision))
		else $error("result word changed while stalled");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2 && !inr_s2) |=> (edge_out == '0))
		else $error("out-of-range node produced edge bits");

	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2 && (op_s2 == OP_LOAD)) |=> (edge_out == '0) && !decision)
		else $error("load word produced nonzero result");

endmodule
